/* src/tcw_pkg.sv */
// Types and constants shared by the text console writer.
package tcw_pkg;

    localparam logic [1:0] MODE_PUT       = 2'd0;
    localparam logic [1:0] MODE_BACKSPACE = 2'd1;
    localparam logic [1:0] MODE_READ      = 2'd2;
    localparam logic [1:0] MODE_CLEAR     = 2'd3;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_BLANK   = 8'h08;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ERROR   = 8'h45;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 1'b1;

    localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } cell_t;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_ZERO   = 8'b0010_0000,
        S_FILL   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

endpackage

/* src/text_console_writer_top.sv */
// Character-cell text console: cell memory, cursor and result register.
//
// Text console of COLUMNS x ROWS cells (character low byte, attribute high byte)
// held in one synchronous single-read, single-write memory, with a cursor kept as
// column and row. One transaction in gives one transaction out. After reset the
// block clears the memory to zero, one cell a cycle, before s_tready first rises;
// configuration writes are taken throughout. After acceptance a put, backspace
// or out-of-range access passes through S_EXEC and S_DONE before m_tvalid rises,
// a read through S_EXEC, S_READ and S_DONE. A put that scrolls copies the screen
// up one cell a cycle through the memory and zeroes the last row. Clear writes
// every cell once. One item is in work at a time; the next is accepted as soon
// as its result sits in the output register, while that result waits for
// m_tready.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // character[7:0], attribute[15:8], use_cursor[16], column[24:17], row[30:25]
    input  logic [31:0]          s_tdata,
    // mode[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cursor_column[6:0], cursor_row[11:7], read_character[19:12],
    // read_attribute[27:20], position_error[28], scrolled[29]
    output logic [31:0]          m_tdata
);

    localparam int unsigned CELLS  = COLUMNS * ROWS;
    localparam int unsigned ADDR_W = $clog2(CELLS);
    localparam int unsigned COL_W  = $clog2(COLUMNS);
    localparam int unsigned ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_A  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [COL_W:0]    COLS_X      = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W:0]    ROWS_X      = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

    cell_t cell_mem [CELLS];
    cell_t mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    cell_t             mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [7:0]        def_attr_reg, def_attr_next;
    logic [7:0]        err_attr_reg, err_attr_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    logic [1:0]        mode_reg, mode_next;
    logic [7:0]        ch_reg, ch_next;
    logic [7:0]        attr_reg, attr_next;
    logic              use_cur_reg, use_cur_next;
    logic [7:0]        col_reg, col_next;
    logic [5:0]        row_reg, row_next;
    cell_t             res_cell_reg, res_cell_next;
    logic              perr_reg, perr_next;
    logic              scr_reg, scr_next;

    logic              accept;
    logic              bad;
    logic              at_cursor;
    logic [COL_W-1:0]  eff_col;
    logic [ROW_W-1:0]  eff_row;
    logic [ADDR_W-1:0] pos_addr;
    logic [7:0]        put_attr;
    logic [COL_W:0]    col_inc;
    logic [COL_W-1:0]  adv_col;
    logic [ROW_W:0]    adv_row;
    logic              cursor_home;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign bad = !use_cur_reg && ((col_reg >= 8'(COLUMNS)) || (row_reg >= 6'(ROWS)));
    assign at_cursor = use_cur_reg || (mode_reg == MODE_BACKSPACE);
    assign eff_col = at_cursor ? cur_col_reg : COL_W'(col_reg);
    assign eff_row = at_cursor ? cur_row_reg : ROW_W'(row_reg);
    assign pos_addr = ADDR_W'(eff_row) * COLS_A + ADDR_W'(eff_col);
    assign put_attr = (attr_reg == 8'd0) ? def_attr_reg : attr_reg;
    assign col_inc = {1'b0, eff_col} + 1'b1;
    assign cursor_home = (cur_col_reg == '0) && (cur_row_reg == '0);
    assign mem_raddr = (state_reg == S_SCROLL) ? ptr_reg : pos_addr;

    always_comb begin
        if (ch_reg == CH_NEWLINE) begin
            adv_col = '0;
            adv_row = {1'b0, eff_row} + 1'b1;
        end else if (ch_reg == CH_BLANK) begin
            adv_col = eff_col;
            adv_row = {1'b0, eff_row};
        end else if (col_inc == COLS_X) begin
            adv_col = '0;
            adv_row = {1'b0, eff_row} + 1'b1;
        end else begin
            adv_col = col_inc[COL_W-1:0];
            adv_row = {1'b0, eff_row};
        end
    end

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        def_attr_next  = def_attr_reg;
        err_attr_next  = err_attr_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        mode_next      = mode_reg;
        ch_next        = ch_reg;
        attr_next      = attr_reg;
        use_cur_next   = use_cur_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        res_cell_next  = res_cell_reg;
        perr_next      = perr_reg;
        scr_next       = scr_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_addr;
        mem_wdata      = '0;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_DEFAULT_ATTR: def_attr_next = cfg_wdata;
                REG_ERROR_ATTR:   err_attr_next = cfg_wdata;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = '0;
                if (ptr_reg == LAST_CELL) begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    mode_next    = s_tuser;
                    ch_next      = s_tdata[7:0];
                    attr_next    = s_tdata[15:8];
                    use_cur_next = s_tdata[16];
                    col_next     = s_tdata[24:17];
                    row_next     = s_tdata[30:25];
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                res_cell_next = '0;
                perr_next     = 1'b0;
                scr_next      = 1'b0;
                state_next    = S_DONE;
                unique case (mode_reg)
                    MODE_PUT: begin
                        if (bad) begin
                            mem_we    = 1'b1;
                            mem_waddr = LAST_CELL;
                            mem_wdata = '{attr: err_attr_reg, ch: CH_ERROR};
                            perr_next = 1'b1;
                        end else begin
                            mem_we    = (ch_reg != CH_NEWLINE);
                            mem_wdata = '{attr: put_attr,
                                          ch: (ch_reg == CH_BLANK) ? CH_SPACE : ch_reg};
                            cur_col_next = adv_col;
                            if (adv_row == ROWS_X) begin
                                cur_row_next = LAST_ROW;
                                scr_next     = 1'b1;
                                ptr_next     = COLS_A;
                                pend_next    = 1'b0;
                                state_next   = S_SCROLL;
                            end else begin
                                cur_row_next = adv_row[ROW_W-1:0];
                            end
                        end
                    end
                    MODE_BACKSPACE: begin
                        mem_we    = 1'b1;
                        mem_wdata = '{attr: def_attr_reg, ch: CH_SPACE};
                        if (cursor_home) begin
                            mem_waddr = '0;
                        end else begin
                            mem_waddr = pos_addr - 1'b1;
                            if (cur_col_reg == '0) begin
                                cur_col_next = LAST_COL;
                                cur_row_next = cur_row_reg - 1'b1;
                            end else begin
                                cur_col_next = cur_col_reg - 1'b1;
                            end
                        end
                    end
                    MODE_READ: begin
                        if (bad) begin
                            perr_next = 1'b1;
                        end else begin
                            state_next = S_READ;
                        end
                    end
                    MODE_CLEAR: begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        ptr_next     = '0;
                        state_next   = S_FILL;
                    end
                endcase
            end
            S_READ: begin
                res_cell_next = mem_rdata_reg;
                state_next    = S_DONE;
            end
            S_SCROLL: begin
                mem_we         = pend_reg;
                mem_waddr      = pend_addr_reg;
                mem_wdata      = mem_rdata_reg;
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg - COLS_A;
                if (ptr_reg == LAST_CELL) begin
                    ptr_next   = LAST_ROW_A;
                    state_next = S_ZERO;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_ZERO: begin
                mem_we = 1'b1;
                if (pend_reg) begin
                    mem_waddr = pend_addr_reg;
                    mem_wdata = mem_rdata_reg;
                    pend_next = 1'b0;
                end else begin
                    mem_waddr = ptr_reg;
                    mem_wdata = '0;
                    if (ptr_reg == LAST_CELL) begin
                        state_next = S_DONE;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = '{attr: def_attr_reg, ch: CH_SPACE};
                if (ptr_reg == LAST_CELL) begin
                    state_next = S_DONE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, scr_reg, perr_reg, res_cell_reg.attr,
                                     res_cell_reg.ch, 5'(cur_row_reg), 7'(cur_col_reg)};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            ptr_reg      <= '0;
            pend_reg     <= 1'b0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            def_attr_reg <= DEFAULT_ATTR_RST;
            err_attr_reg <= ERROR_ATTR_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            pend_reg     <= pend_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            def_attr_reg <= def_attr_next;
            err_attr_reg <= err_attr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        m_tdata_reg   <= m_tdata_next;
        mode_reg      <= mode_next;
        ch_reg        <= ch_next;
        attr_reg      <= attr_next;
        use_cur_reg   <= use_cur_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        res_cell_reg  <= res_cell_next;
        perr_reg      <= perr_next;
        scr_reg       <= scr_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= cell_mem[mem_raddr];
    end

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_col_reg <= LAST_COL) && (cur_row_reg <= LAST_ROW))
        else $error("cursor outside the screen");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("cell memory written while idle");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted transaction not executed");

    a_scroll_keeps_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCROLL) |-> (cur_row_reg == LAST_ROW))
        else $error("scroll with cursor off the last row");
`endif

endmodule
